// ===== design/rbb_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rbb_pkg: shared constants for the rotated bounding box
// Field widths, register indexes and reset values used by the interfaces and
// the datapath.
// ----------------------------------------------------------------------------
package rbb_pkg;

    // Vertex coordinates and box fields are signed Q16.16.
    localparam int POS_W = 32;

    // Matrix coefficients are signed Q2.14, three to a row register.
    localparam int COEF_W    = 16;
    localparam int COEF_FRAC = 14;
    localparam int ROW_W     = 3 * COEF_W;

    // Default saturation width of a transformed coordinate.
    localparam int COORD_WIDTH_DEF = 32;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = ROW_W;

    localparam logic [CFG_IDX_W-1:0] CFG_ROW_X    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_Y    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_Z    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_X = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_Y = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_Z = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_ROT_ONLY = 3'd6;

    // Identity matrix after reset: a coefficient of 1.0 on the diagonal.
    localparam logic [ROW_W-1:0] ROW_X_RST = 48'h0000_0000_4000;
    localparam logic [ROW_W-1:0] ROW_Y_RST = 48'h0000_4000_0000;
    localparam logic [ROW_W-1:0] ROW_Z_RST = 48'h4000_0000_0000;

endpackage : rbb_pkg
`default_nettype wire

// ===== design/rbb_vtx_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rbb_vtx_if: vertex channel
// Valid/ready channel carrying one mesh vertex and its end-of-mesh mark.
// ----------------------------------------------------------------------------
interface rbb_vtx_if;
    import rbb_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
    logic                    last_vertex;

    modport source (output valid, pos_x, pos_y, pos_z, last_vertex, input ready);
    modport sink   (input valid, pos_x, pos_y, pos_z, last_vertex, output ready);
endinterface : rbb_vtx_if
`default_nettype wire

// ===== design/rbb_box_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rbb_box_if: bounding box channel
// Valid/ready channel carrying the minimum, maximum and center of a mesh.
// ----------------------------------------------------------------------------
interface rbb_box_if;
    import rbb_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [POS_W-1:0] min_x;
    logic signed [POS_W-1:0] min_y;
    logic signed [POS_W-1:0] min_z;
    logic signed [POS_W-1:0] max_x;
    logic signed [POS_W-1:0] max_y;
    logic signed [POS_W-1:0] max_z;
    logic signed [POS_W-1:0] center_x;
    logic signed [POS_W-1:0] center_y;
    logic signed [POS_W-1:0] center_z;

    modport source (output valid, min_x, min_y, min_z, max_x, max_y, max_z,
                    center_x, center_y, center_z, input ready);
    modport sink   (input valid, min_x, min_y, min_z, max_x, max_y, max_z,
                    center_x, center_y, center_z, output ready);
endinterface : rbb_box_if
`default_nettype wire

// ===== design/rotated_bounding_box.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rotated_bounding_box: bounding box of a rotated and offset mesh
// Rotates each vertex by a 3x3 matrix, adds an offset, saturates, tracks the
// per-axis minimum and maximum and reports the box on the last vertex.
// ----------------------------------------------------------------------------
// Usage:
// Vertices enter on i_vtx, one transfer per vertex, as signed Q16.16 x, y, z
// with last_vertex set on the final vertex of a mesh. Only that final vertex
// produces a transfer on o_box: the minimum, maximum and center of all
// transformed vertices of the mesh, including the final one. The running box
// then re-arms for the next mesh.
// The matrix rows, the offsets and the rotation-only flag are written through
// the plain write port (i_cfg_we, i_cfg_idx, i_cfg_data) while no mesh is in
// flight. Writes to an index past the register list are dropped.
// Throughput is one vertex per clock unless a stall on o_box holds off the
// input. The datapath is a five-register pipeline: input register, nine
// 16x32 products, row sum with offset and saturation, box accumulator, and
// the output register where the center is formed. A box passes through these
// registers in order and appears on o_box from the output register.
// When o_box stalls, vertices that are not the last of a mesh keep flowing;
// a finished box waits in a holding register, so a second box can complete
// behind the one on the output before the input is held off.
// Reset restores the identity matrix, zero offsets, clears every valid bit
// and re-arms the box: minimum at the most positive and maximum at the most
// negative saturated value.
// ----------------------------------------------------------------------------
module rotated_bounding_box #(
    parameter int COORD_WIDTH = rbb_pkg::COORD_WIDTH_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [rbb_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [rbb_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    rbb_vtx_if.sink                              i_vtx,
    rbb_box_if.source                            o_box
);
    import rbb_pkg::*;

    // Three products of 48 bits plus a shifted offset fit in 50 bits.
    localparam int PROD_W = COEF_W + POS_W;
    localparam int SUM_W  = PROD_W + 2;
    localparam int CW1    = COORD_WIDTH + 1;

    localparam logic signed [SUM_W-1:0] SAT_MAX =
        SUM_W'((64'sd1 <<< (COORD_WIDTH - 1)) - 64'sd1);
    localparam logic signed [SUM_W-1:0] SAT_MIN = ~SAT_MAX;
    localparam logic signed [COORD_WIDTH-1:0] CRD_MAX = SAT_MAX[COORD_WIDTH-1:0];
    localparam logic signed [COORD_WIDTH-1:0] CRD_MIN = SAT_MIN[COORD_WIDTH-1:0];

    // Configuration registers.
    logic        [ROW_W-1:0]  r_row [3];
    logic signed [POS_W-1:0]  r_off [3];
    logic                     r_rot_only;

    // Stage 1: input register.
    logic                     r_v1;
    logic                     r_last1;
    logic signed [POS_W-1:0]  r_pos [3];

    // Stage 2: products, indexed by output axis and input axis.
    logic                     r_v2;
    logic                     r_last2;
    logic signed [PROD_W-1:0] r_prod [3][3];
    logic signed [PROD_W-1:0] n_prod [3][3];

    // Stage 3: transformed and saturated coordinates.
    logic                          r_v3;
    logic                          r_last3;
    logic signed [COORD_WIDTH-1:0] r_crd [3];
    logic signed [COORD_WIDTH-1:0] n_crd [3];

    // Running box.
    logic signed [COORD_WIDTH-1:0] r_lo [3];
    logic signed [COORD_WIDTH-1:0] r_hi [3];
    logic signed [COORD_WIDTH-1:0] n_lo [3];
    logic signed [COORD_WIDTH-1:0] n_hi [3];

    // Stage 4: finished box waiting for the output register.
    logic                          r_fv;
    logic                          n_fv;
    logic signed [COORD_WIDTH-1:0] r_flo [3];
    logic signed [COORD_WIDTH-1:0] r_fhi [3];

    // Stage 5: output register.
    logic                          r_ov;
    logic                          n_ov;
    logic signed [COORD_WIDTH-1:0] r_olo [3];
    logic signed [COORD_WIDTH-1:0] r_ohi [3];
    logic signed [COORD_WIDTH-1:0] r_octr [3];
    logic signed [COORD_WIDTH-1:0] n_octr [3];

    // Flow control. Each stage moves when the one after it can take its item.
    // A vertex that is not last leaves stage 3 without needing stage 4.
    logic rdy1, rdy2, rdy3, rdy4, rdy5;
    logic lv3;

    assign rdy5 = !r_ov || o_box.ready;
    assign rdy4 = !r_fv || rdy5;
    assign lv3  = r_v3 && (!r_last3 || rdy4);
    assign rdy3 = !r_v3 || lv3;
    assign rdy2 = !r_v2 || rdy3;
    assign rdy1 = !r_v1 || rdy2;

    assign i_vtx.ready = rdy1;

    assign n_fv = (r_fv && !rdy5) || (lv3 && r_last3);
    assign n_ov = (r_ov && !o_box.ready) || (r_fv && rdy5);

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row[0]   <= ROW_X_RST;
            r_row[1]   <= ROW_Y_RST;
            r_row[2]   <= ROW_Z_RST;
            r_off[0]   <= '0;
            r_off[1]   <= '0;
            r_off[2]   <= '0;
            r_rot_only <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ROW_X:    r_row[0]   <= i_cfg_data[ROW_W-1:0];
                CFG_ROW_Y:    r_row[1]   <= i_cfg_data[ROW_W-1:0];
                CFG_ROW_Z:    r_row[2]   <= i_cfg_data[ROW_W-1:0];
                CFG_OFFSET_X: r_off[0]   <= i_cfg_data[POS_W-1:0];
                CFG_OFFSET_Y: r_off[1]   <= i_cfg_data[POS_W-1:0];
                CFG_OFFSET_Z: r_off[2]   <= i_cfg_data[POS_W-1:0];
                CFG_ROT_ONLY: r_rot_only <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // Nine independent coefficient-by-coordinate products.
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            for (int k = 0; k < 3; k++) begin
                n_prod[a][k] = PROD_W'($signed(r_row[a][COEF_W*k +: COEF_W]))
                             * PROD_W'(r_pos[k]);
            end
        end
    end

    // Row sum. The offset is added before the shift at the product scale,
    // which gives the same floor as shifting first and adding after.
    always_comb begin
        logic signed [SUM_W-1:0] sum;
        logic signed [SUM_W-1:0] off_sh;
        logic signed [SUM_W-1:0] shifted;
        for (int a = 0; a < 3; a++) begin
            off_sh  = r_rot_only ? '0 : (SUM_W'(r_off[a]) <<< COEF_FRAC);
            sum     = SUM_W'(r_prod[a][0]) + SUM_W'(r_prod[a][1])
                    + SUM_W'(r_prod[a][2]) + off_sh;
            shifted = sum >>> COEF_FRAC;
            if (shifted > SAT_MAX) begin
                n_crd[a] = CRD_MAX;
            end else if (shifted < SAT_MIN) begin
                n_crd[a] = CRD_MIN;
            end else begin
                n_crd[a] = shifted[COORD_WIDTH-1:0];
            end
        end
    end

    // Box update with the vertex leaving stage 3.
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            n_lo[a] = (r_crd[a] < r_lo[a]) ? r_crd[a] : r_lo[a];
            n_hi[a] = (r_crd[a] > r_hi[a]) ? r_crd[a] : r_hi[a];
        end
    end

    // Center as the floor of the mean, with one guard bit against overflow.
    always_comb begin
        logic signed [CW1-1:0] pair;
        for (int a = 0; a < 3; a++) begin
            pair      = CW1'(r_flo[a]) + CW1'(r_fhi[a]);
            n_octr[a] = pair[CW1-1:1];
        end
    end

    // Valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_fv <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            if (rdy1) begin
                r_v1 <= i_vtx.valid;
            end
            if (rdy2) begin
                r_v2 <= r_v1;
            end
            if (rdy3) begin
                r_v3 <= r_v2;
            end
            r_fv <= n_fv;
            r_ov <= n_ov;
        end
    end

    // Running box: re-armed by reset and after every last vertex.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < 3; a++) begin
                r_lo[a] <= CRD_MAX;
                r_hi[a] <= CRD_MIN;
            end
        end else if (lv3) begin
            for (int a = 0; a < 3; a++) begin
                r_lo[a] <= r_last3 ? CRD_MAX : n_lo[a];
                r_hi[a] <= r_last3 ? CRD_MIN : n_hi[a];
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (rdy1 && i_vtx.valid) begin
            r_pos[0] <= i_vtx.pos_x;
            r_pos[1] <= i_vtx.pos_y;
            r_pos[2] <= i_vtx.pos_z;
            r_last1  <= i_vtx.last_vertex;
        end
        if (rdy2 && r_v1) begin
            r_prod  <= n_prod;
            r_last2 <= r_last1;
        end
        if (rdy3 && r_v2) begin
            r_crd   <= n_crd;
            r_last3 <= r_last2;
        end
        if (lv3 && r_last3) begin
            r_flo <= n_lo;
            r_fhi <= n_hi;
        end
        if (r_fv && rdy5) begin
            r_olo  <= r_flo;
            r_ohi  <= r_fhi;
            r_octr <= n_octr;
        end
    end

    assign o_box.valid    = r_ov;
    assign o_box.min_x    = POS_W'(r_olo[0]);
    assign o_box.min_y    = POS_W'(r_olo[1]);
    assign o_box.min_z    = POS_W'(r_olo[2]);
    assign o_box.max_x    = POS_W'(r_ohi[0]);
    assign o_box.max_y    = POS_W'(r_ohi[1]);
    assign o_box.max_z    = POS_W'(r_ohi[2]);
    assign o_box.center_x = POS_W'(r_octr[0]);
    assign o_box.center_y = POS_W'(r_octr[1]);
    assign o_box.center_z = POS_W'(r_octr[2]);

    // Every reported box holds at least one vertex, so it is never inverted.
    a_box_ordered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov |-> (r_olo[0] <= r_ohi[0]) && (r_olo[1] <= r_ohi[1])
                 && (r_olo[2] <= r_ohi[2]))
        else $error("reported box has minimum above maximum");

    // On the x axis, the center lies between the minimum and the maximum.
    a_center_inside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov |-> (r_octr[0] >= r_olo[0]) && (r_octr[0] <= r_ohi[0]))
        else $error("center outside the reported box");

    // Without a box waiting in the holding register the input never stalls.
    a_no_false_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_fv |-> i_vtx.ready)
        else $error("input held off with an empty holding register");

    // Reset re-arms the running box, checked on the x and z axes.
    a_reset_rearm: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_lo[0] == CRD_MAX) && (r_hi[0] == CRD_MIN)
                     && (r_lo[2] == CRD_MAX) && (r_hi[2] == CRD_MIN))
        else $error("running box not re-armed by reset");

endmodule : rotated_bounding_box
`default_nettype wire

// ===== tb/rbb_box_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rbb_box_checker: bounding box scoreboard
// Watches the register writes and both channels. It transforms every vertex
// that is transferred in, tracks the running box, and compares each box
// transfer with the oldest box still owed.
// ----------------------------------------------------------------------------
module rbb_box_checker #(
    parameter int COORD_WIDTH = rbb_pkg::COORD_WIDTH_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [rbb_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [rbb_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    rbb_vtx_if                                   i_vtx,
    rbb_box_if                                   i_box,
    output int                                   o_fail_count,
    output int                                   o_boxes_due
);
    import rbb_pkg::*;

    localparam longint COORD_HI = (64'sd1 <<< (COORD_WIDTH - 1)) - 64'sd1;
    localparam longint COORD_LO = -COORD_HI - 64'sd1;

    typedef logic signed [POS_W-1:0] t_coord;

    // Index 0 is x, 1 is y, 2 is z.
    typedef struct packed {
        t_coord [2:0] lo;
        t_coord [2:0] hi;
        t_coord [2:0] mid;
    } t_box;

    logic [ROW_W-1:0] matrix_row [3];
    longint           axis_offset [3];
    logic             skip_offset;
    longint           run_min [3];
    longint           run_max [3];
    t_box             boxes_owed [$];
    string            axis_tag [3] = '{"x", "y", "z"};

    task automatic rearm_box();
        int a;
        for (a = 0; a < 3; a++) begin
            run_min[a] = COORD_HI;
            run_max[a] = COORD_LO;
        end
    endtask

    // Rotate, offset and saturate one vertex, then fold it into the box.
    task automatic fold_vertex(input t_coord px, input t_coord py, input t_coord pz,
                               input logic last);
        longint pos [3];
        longint acc;
        longint v;
        int     a;
        int     k;
        t_box   b;
        pos[0] = px;
        pos[1] = py;
        pos[2] = pz;
        for (a = 0; a < 3; a++) begin
            acc = 0;
            for (k = 0; k < 3; k++)
                acc += longint'($signed(matrix_row[a][COEF_W*k +: COEF_W])) * pos[k];
            v = acc >>> COEF_FRAC;
            if (!skip_offset)
                v += axis_offset[a];
            if (v > COORD_HI)
                v = COORD_HI;
            else if (v < COORD_LO)
                v = COORD_LO;
            if (v < run_min[a])
                run_min[a] = v;
            if (v > run_max[a])
                run_max[a] = v;
        end
        if (last) begin
            for (a = 0; a < 3; a++) begin
                b.lo[a]  = t_coord'(run_min[a]);
                b.hi[a]  = t_coord'(run_max[a]);
                b.mid[a] = t_coord'((run_min[a] + run_max[a]) >>> 1);
            end
            boxes_owed.push_back(b);
            o_boxes_due++;
            rearm_box();
        end
    endtask

    task automatic compare_field(input string name, input t_coord want, input t_coord got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            o_fail_count++;
        end
    endtask

    task automatic check_box();
        t_box want;
        t_box got;
        int   a;
        got.lo  = {i_box.min_z, i_box.min_y, i_box.min_x};
        got.hi  = {i_box.max_z, i_box.max_y, i_box.max_x};
        got.mid = {i_box.center_z, i_box.center_y, i_box.center_x};
        if (boxes_owed.size() == 0) begin
            $error("box transfer with no finished mesh outstanding");
            o_fail_count++;
        end else begin
            want = boxes_owed.pop_front();
            o_boxes_due--;
            for (a = 0; a < 3; a++) begin
                compare_field({"min_", axis_tag[a]}, want.lo[a], got.lo[a]);
                compare_field({"max_", axis_tag[a]}, want.hi[a], got.hi[a]);
                compare_field({"center_", axis_tag[a]}, want.mid[a], got.mid[a]);
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            matrix_row[0] = ROW_X_RST;
            matrix_row[1] = ROW_Y_RST;
            matrix_row[2] = ROW_Z_RST;
            axis_offset[0] = 0;
            axis_offset[1] = 0;
            axis_offset[2] = 0;
            skip_offset = 1'b0;
            rearm_box();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_ROW_X:    matrix_row[0] = i_cfg_data[ROW_W-1:0];
                    CFG_ROW_Y:    matrix_row[1] = i_cfg_data[ROW_W-1:0];
                    CFG_ROW_Z:    matrix_row[2] = i_cfg_data[ROW_W-1:0];
                    CFG_OFFSET_X: axis_offset[0] = longint'($signed(i_cfg_data[POS_W-1:0]));
                    CFG_OFFSET_Y: axis_offset[1] = longint'($signed(i_cfg_data[POS_W-1:0]));
                    CFG_OFFSET_Z: axis_offset[2] = longint'($signed(i_cfg_data[POS_W-1:0]));
                    CFG_ROT_ONLY: skip_offset = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_box.valid && i_box.ready)
                check_box();
            if (i_vtx.valid && i_vtx.ready)
                fold_vertex(i_vtx.pos_x, i_vtx.pos_y, i_vtx.pos_z, i_vtx.last_vertex);
        end
    end

endmodule : rbb_box_checker
`default_nettype wire

// ===== tb/rotated_bounding_box_tb.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rotated_bounding_box_tb: stimulus and verdict for the rotated bounding box
// Streams meshes through the block under a series of matrix and offset
// settings, with random gaps on the vertex side and random stalls on the box
// side. A checker beside the block predicts every box and counts mismatches.
// ----------------------------------------------------------------------------
module rotated_bounding_box_tb;
    import rbb_pkg::*;

    localparam int COORD_WIDTH  = COORD_WIDTH_DEF;
    localparam int CLK_HALF     = 10;
    localparam int RESET_CYCLES = 7;
    // Settling time after the last box, covering the pipeline and the holding
    // register behind the output.
    localparam int PIPE_SETTLE  = 8;
    // Consecutive cycles without any transfer before the run is declared hung.
    localparam int QUIET_LIMIT  = 2000;
    localparam int RANDOM_VERTICES   = 1300;
    localparam int VERTICES_PER_SETTING = 130;
    localparam int NORMAL_IDLE_PCT  = 24;

    // Index 7 is past the register list; writes there must be dropped.
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 3'd7;

    localparam logic [COEF_W-1:0] COEF_MINUS_TWO = 16'h8000;
    localparam logic [COEF_W-1:0] COEF_MAX       = 16'h7FFF;
    localparam logic [COEF_W-1:0] COEF_ONE       = 16'h4000;
    localparam logic [COEF_W-1:0] COEF_MINUS_ONE = 16'hC000;

    localparam logic signed [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
    localparam logic signed [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};

    typedef logic signed [POS_W-1:0] t_coord;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    int fail_count;
    int boxes_due;
    int src_idle_pct;
    int sink_idle_pct;
    int quiet_cycles;
    int vertex_count;
    int mesh_count;
    int setting_count;

    rbb_vtx_if vtx_ch ();
    rbb_box_if box_ch ();

    rotated_bounding_box #(
        .COORD_WIDTH (COORD_WIDTH)
    ) dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_vtx      (vtx_ch),
        .o_box      (box_ch)
    );

    rbb_box_checker #(
        .COORD_WIDTH (COORD_WIDTH)
    ) box_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .i_vtx        (vtx_ch),
        .i_box        (box_ch),
        .o_fail_count (fail_count),
        .o_boxes_due  (boxes_due)
    );

    always begin
        clk = 1'b0;
        #CLK_HALF;
        clk = 1'b1;
        #CLK_HALF;
    end

    // The box side stalls at random. The decision is redrawn every cycle, so
    // stalls land on any point of the pipeline's work, including the cycles
    // where a second box is queued behind the one on the output.
    initial begin
        box_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            box_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    // Watchdog: a run that stops transferring in either direction is hung.
    always @(posedge clk) begin
        if ((vtx_ch.valid && vtx_ch.ready) || (box_ch.valid && box_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offers one vertex and returns at the edge where it is transferred. The
    // valid line is left high, so a following vertex goes out back to back
    // unless the next call chooses to idle first.
    task automatic send_vertex(input t_coord px, input t_coord py, input t_coord pz,
                               input logic last);
        while ($urandom_range(99) < src_idle_pct) begin
            vtx_ch.valid <= 1'b0;
            @(posedge clk);
        end
        vtx_ch.valid       <= 1'b1;
        vtx_ch.pos_x       <= px;
        vtx_ch.pos_y       <= py;
        vtx_ch.pos_z       <= pz;
        vtx_ch.last_vertex <= last;
        do
            @(posedge clk);
        while (!vtx_ch.ready);
        vertex_count++;
        if (last)
            mesh_count++;
    endtask

    // Waits for every owed box to arrive, then lets the pipeline settle so
    // that a register write cannot land on a vertex still in flight. The
    // owed count is read on the falling edge, after the checker has seen the
    // rising edge of the last transfer.
    task automatic drain();
        vtx_ch.valid <= 1'b0;
        @(negedge clk);
        while (boxes_due != 0)
            @(negedge clk);
        repeat (PIPE_SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge clk);
    endtask

    // Writes all seven registers plus one write past the end of the list.
    // Bits above each register's width carry noise, which the block must drop.
    task automatic load_setting(input logic [ROW_W-1:0] rx, input logic [ROW_W-1:0] ry,
                                input logic [ROW_W-1:0] rz, input t_coord ox,
                                input t_coord oy, input t_coord oz, input logic rot);
        logic [63:0] noise;
        noise = {$urandom(), $urandom()};
        write_reg(CFG_ROW_X, rx);
        write_reg(CFG_ROW_Y, ry);
        write_reg(CFG_ROW_Z, rz);
        write_reg(CFG_OFFSET_X, {noise[CFG_DATA_W-POS_W-1:0], ox});
        write_reg(CFG_OFFSET_Y, {noise[CFG_DATA_W-POS_W+15:16], oy});
        write_reg(CFG_OFFSET_Z, {noise[CFG_DATA_W-POS_W+31:32], oz});
        write_reg(CFG_UNMAPPED, noise[CFG_DATA_W-1:0]);
        write_reg(CFG_ROT_ONLY, {noise[CFG_DATA_W-1:1], rot});
        cfg_we <= 1'b0;
        setting_count++;
    endtask

    // Coordinates: the two extremes, small values near the origin, and full-range
    // noise.
    function automatic t_coord rand_coord();
        case ($urandom_range(15))
            0:          return POS_MAX;
            1:          return POS_MIN;
            2, 3, 4, 5: return int'($urandom_range(2097151)) - 1048576;
            default:    return $urandom();
        endcase
    endfunction

    function automatic logic [COEF_W-1:0] rand_coef();
        case ($urandom_range(7))
            0:       return COEF_MINUS_TWO;
            1:       return COEF_MAX;
            2:       return '0;
            3:       return COEF_ONE;
            4:       return COEF_MINUS_ONE;
            default: return $urandom();
        endcase
    endfunction

    function automatic t_coord rand_offset();
        case ($urandom_range(7))
            0:       return POS_MAX;
            1:       return POS_MIN;
            2:       return '0;
            3, 4:    return int'($urandom_range(4194303)) - 2097152;
            default: return $urandom();
        endcase
    endfunction

    task automatic send_mesh(input int len);
        int i;
        for (i = 1; i <= len; i++)
            send_vertex(rand_coord(), rand_coord(), rand_coord(), i == len);
    endtask

    initial begin
        int sent;
        int target;
        int len;
        int phase;

        rst_n              <= 1'b0;
        cfg_we             <= 1'b0;
        cfg_idx            <= '0;
        cfg_data           <= '0;
        vtx_ch.valid       <= 1'b0;
        vtx_ch.pos_x       <= '0;
        vtx_ch.pos_y       <= '0;
        vtx_ch.pos_z       <= '0;
        vtx_ch.last_vertex <= 1'b0;
        src_idle_pct  = NORMAL_IDLE_PCT;
        sink_idle_pct = NORMAL_IDLE_PCT;
        quiet_cycles  = 0;
        vertex_count  = 0;
        mesh_count    = 0;
        setting_count = 0;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset setting: identity matrix, zero offsets. Single-vertex meshes
        // at the origin and at both extremes, then a mesh whose min plus max
        // is odd and negative, so the center rounds toward minus infinity.
        send_vertex('0, '0, '0, 1'b1);
        send_vertex(POS_MAX, POS_MAX, POS_MAX, 1'b1);
        send_vertex(POS_MIN, POS_MIN, POS_MIN, 1'b1);
        send_vertex(-3, -3, -3, 1'b0);
        send_vertex('0, '0, '0, 1'b1);
        // Alternating bit patterns so every coordinate bit is seen at both
        // levels in a single mesh.
        send_vertex(32'hAAAA_AAAA, 32'h5555_5555, -1, 1'b0);
        send_vertex(32'h5555_5555, 32'hAAAA_AAAA, 1, 1'b0);
        send_vertex(POS_MAX, POS_MIN, '0, 1'b0);
        send_vertex(POS_MIN, POS_MAX, '0, 1'b1);
        drain();

        // Every coefficient at minus two with the largest offsets: large
        // coordinates push every axis into saturation in both directions.
        load_setting({3{COEF_MINUS_TWO}}, {3{COEF_MINUS_TWO}}, {3{COEF_MINUS_TWO}},
                     POS_MAX, POS_MAX, POS_MAX, 1'b0);
        send_vertex(POS_MIN, POS_MIN, POS_MIN, 1'b0);
        send_vertex(POS_MAX, POS_MAX, POS_MAX, 1'b1);
        send_vertex('0, '0, '0, 1'b1);
        drain();

        // Largest positive coefficients with the most negative offsets.
        load_setting({3{COEF_MAX}}, {3{COEF_MAX}}, {3{COEF_MAX}},
                     POS_MIN, POS_MIN, POS_MIN, 1'b0);
        send_vertex(POS_MIN, POS_MIN, POS_MIN, 1'b0);
        send_vertex(POS_MAX, POS_MAX, POS_MAX, 1'b0);
        send_vertex(1, -1, '0, 1'b1);
        drain();

        // Rotation only: the offsets are loaded but must not be applied.
        load_setting(ROW_X_RST, ROW_Y_RST, ROW_Z_RST, POS_MAX, POS_MIN, 12345, 1'b1);
        send_vertex(5, -5, 7, 1'b1);
        send_vertex(POS_MAX, POS_MIN, '0, 1'b1);
        drain();

        // Random part: a fresh random setting per phase, then meshes of
        // random length, mostly short so that boxes come often. Phase two
        // runs with no gaps and no stalls at all.
        sent  = 0;
        phase = 0;
        while (sent < RANDOM_VERTICES) begin
            if (phase == 2) begin
                src_idle_pct  = 0;
                sink_idle_pct = 0;
            end else begin
                src_idle_pct  = NORMAL_IDLE_PCT;
                sink_idle_pct = NORMAL_IDLE_PCT;
            end
            load_setting({rand_coef(), rand_coef(), rand_coef()},
                         {rand_coef(), rand_coef(), rand_coef()},
                         {rand_coef(), rand_coef(), rand_coef()},
                         rand_offset(), rand_offset(), rand_offset(),
                         1'($urandom_range(1)));
            target = sent + VERTICES_PER_SETTING;
            while (sent < target) begin
                len = ($urandom_range(3) == 0) ? $urandom_range(40, 1)
                                               : $urandom_range(8, 1);
                send_mesh(len);
                sent += len;
            end
            drain();
            phase++;
        end

        $display("Sent %0d vertices in %0d meshes under %0d register settings,",
                 vertex_count, mesh_count, setting_count);
        $display("covering extreme coefficients, saturation and rotation-only mode.");
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule : rotated_bounding_box_tb
`default_nettype wire

// ===== files.f =====
design/rbb_pkg.sv
design/rbb_vtx_if.sv
design/rbb_box_if.sv
design/rotated_bounding_box.sv
tb/rbb_box_checker.sv
tb/rotated_bounding_box_tb.sv
